>>> rtl/core/trp_pkg.sv
// Shared types and constants of the trapezoidal rate profile unit.
// Used by trp_cfg, trp_mul and trapezoidal_rate_profile_unit; no dependencies.
package trp_pkg;

  localparam int COUNT_WIDTH_DEF = 22;

  localparam int RATE_WIDTH  = 32;
  localparam int ANGLE_WIDTH = 48;
  localparam int UP_WIDTH    = 16;
  localparam int HOLD_WIDTH  = 20;
  localparam int DOWN_WIDTH  = 16;

  // up + hold + down fits here
  localparam int SUM_WIDTH   = 21;
  // full product width of the serial multiplier
  localparam int PROD_WIDTH  = 64;
  // doubled angle, one bit above the angle output
  localparam int ACC_WIDTH   = ANGLE_WIDTH + 1;

  localparam int CFG_IDX_WIDTH  = 3;
  localparam int CFG_DATA_WIDTH = 32;

  localparam logic [CFG_IDX_WIDTH-1:0] REG_RATE_STEP  = 3'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_PEAK_RATE  = 3'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_UP_TICKS   = 3'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_HOLD_TICKS = 3'd3;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_DOWN_TICKS = 3'd4;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;

  localparam logic [1:0] PH_UP   = 2'd0;
  localparam logic [1:0] PH_HOLD = 2'd1;
  localparam logic [1:0] PH_DOWN = 2'd2;
  localparam logic [1:0] PH_STOP = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic       sensors_ready;
  } trp_in_t;

  typedef struct packed {
    logic                   setpoint_valid;
    logic [RATE_WIDTH-1:0]  rate_out;
    logic [ANGLE_WIDTH-1:0] angle_out;
    logic [1:0]             phase;
    logic                   done_res;
    logic                   armed;
  } trp_out_t;

  typedef struct packed {
    logic [RATE_WIDTH-1:0] rate_step;
    logic [RATE_WIDTH-1:0] peak_rate;
    logic [UP_WIDTH-1:0]   up_ticks;
    logic [HOLD_WIDTH-1:0] hold_ticks;
    logic [DOWN_WIDTH-1:0] down_ticks;
  } trp_cfg_t;

endpackage

>>> rtl/core/trp_cfg.sv
// Configuration register file of the trapezoidal rate profile unit.
// Depends on trp_pkg for register indexes and the trp_cfg_t bundle.
module trp_cfg import trp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_WIDTH-1:0]  cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0] cfg_data,
  output trp_cfg_t                  cfg_q
);

  trp_cfg_t cfg_r;
  trp_cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg_q     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_RATE_STEP:  cfg_nxt.rate_step  = cfg_data[RATE_WIDTH-1:0];
        REG_PEAK_RATE:  cfg_nxt.peak_rate  = cfg_data[RATE_WIDTH-1:0];
        REG_UP_TICKS:   cfg_nxt.up_ticks   = cfg_data[UP_WIDTH-1:0];
        REG_HOLD_TICKS: cfg_nxt.hold_ticks = cfg_data[HOLD_WIDTH-1:0];
        REG_DOWN_TICKS: cfg_nxt.down_ticks = cfg_data[DOWN_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rate_step  <= '0;
      cfg_r.peak_rate  <= '0;
      cfg_r.up_ticks   <= UP_WIDTH'(1);
      cfg_r.hold_ticks <= '0;
      cfg_r.down_ticks <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

>>> rtl/core/trp_mul.sv
// Bit-serial shift-add multiplier: one multiplier bit per cycle.
// Depends on trp_pkg for the product width.
module trp_mul import trp_pkg::*; #(
  parameter int B_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  go,
  input  logic [PROD_WIDTH-1:0] a,
  input  logic [B_WIDTH-1:0]    b,
  output logic                  done,
  output logic [PROD_WIDTH-1:0] prod
);

  localparam int CNT_W = $clog2(B_WIDTH + 1);

  logic [PROD_WIDTH-1:0] mcand_r;
  logic [PROD_WIDTH-1:0] acc_r;
  logic [B_WIDTH-1:0]    mplier_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  busy_r;
  logic                  done_r;

  assign done = done_r;
  assign prod = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(B_WIDTH);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: add the shifted multiplicand when the low multiplier bit is set
  always_ff @(posedge clk) begin
    if (go) begin
      mcand_r  <= a;
      mplier_r <= b;
      acc_r    <= '0;
    end else if (busy_r) begin
      acc_r    <= acc_r + (mplier_r[0] ? mcand_r : '0);
      mcand_r  <= {mcand_r[PROD_WIDTH-2:0], 1'b0};
      mplier_r <= {1'b0, mplier_r[B_WIDTH-1:1]};
    end
  end

endmodule

>>> rtl/core/trapezoidal_rate_profile_unit.sv
// Top level of the trapezoidal rate profile unit: control, sequencing, result register.
// Depends on trp_pkg, trp_cfg and trp_mul.
//
// Usage:
//   cfg_*  : register writes (rate_step, peak_rate, up_ticks, hold_ticks, down_ticks),
//            always ready; write only while the unit is idle.
//   in_*   : one item per timer tick or command (tick, start, stop). The unit
//            works on one item at a time; in_stall is high from acceptance until
//            the result has been moved into the output register.
//   out_*  : exactly one result item per input item, in order, held in an
//            output register while out_stall is high. A new input item is
//            accepted while a finished result still waits there.
// Sequencing (BW = max(COUNT_WIDTH, 16), the serial multiplier's bit count):
//   start, stop, ignored ticks and the completing tick go from acceptance
//   through the emit state to the output register. A setpoint tick first runs
//   k multiplies of BW bits each through the one bit-serial multiplier:
//   k = 2 in ramp-up, 3 in the constant phase, 5 in ramp-down. The
//   multiplier sets the rate.
// Reset (synchronous, rst_n low): disarms, clears the tick count and the
//   completion latch, empties the output register and loads register
//   defaults (up_ticks = 1, all others zero).
// When out_stall holds a result, a computed item waits before the output
//   register, and no further item is accepted until it moves there.
module trapezoidal_rate_profile_unit import trp_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  trp_in_t                   in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output trp_out_t                  out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_WIDTH-1:0]  cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0] cfg_data
);

  // multiplier operand width: holds the tick count and up_ticks
  localparam int BW = (COUNT_WIDTH > UP_WIDTH) ? COUNT_WIDTH : UP_WIDTH;
  // width for comparing the tick count with the phase boundaries
  localparam int EW = (BW > SUM_WIDTH) ? BW : SUM_WIDTH;

  typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_EMIT} state_t;

  // multiply steps: operands, and what the product feeds
  typedef enum logic [2:0] {
    SP_ST,  // s*t    -> keep, ramp-up rate
    SP_KT,  // keep*t -> angle (ramp-up)
    SP_SU,  // s*U    -> keep
    SP_KU,  // keep*U -> angle base
    SP_PT,  // p*(t-U) -> angle += 2*prod
    SP_SD,  // s*d    -> keep, ramp-down rate
    SP_KD   // keep*d -> angle -= prod
  } step_t;

  trp_cfg_t cfg;

  state_t                 state_r,    state_nxt;
  step_t                  step_r,     step_nxt;
  logic                   go_r,       go_nxt;
  logic [COUNT_WIDTH-1:0] tick_r,     tick_nxt;
  logic                   running_r,  running_nxt;
  logic                   finished_r, finished_nxt;
  logic                   sp_r,       sp_nxt;
  logic                   donef_r,    donef_nxt;
  logic [1:0]             phase_r,    phase_nxt;
  logic [RATE_WIDTH-1:0]  rate_r,     rate_nxt;
  logic [ACC_WIDTH-1:0]   x_r,        x_nxt;
  logic [PROD_WIDTH-1:0]  keep_r,     keep_nxt;
  logic [BW-1:0]          t_r,        t_nxt;
  logic [BW-1:0]          tu_r,       tu_nxt;
  logic [BW-1:0]          d_r,        d_nxt;
  logic                   out_valid_r, out_valid_nxt;
  trp_out_t               out_data_r,  out_data_nxt;

  logic                   in_accept;
  logic                   advance;
  logic [COUNT_WIDTH-1:0] tick_inc;
  logic [EW-1:0]          t_e, up_e, sd_e, total_e;
  logic [PROD_WIDTH-1:0]  mul_a;
  logic [BW-1:0]          mul_b;
  logic                   mul_done;
  logic [PROD_WIDTH-1:0]  mul_prod;

  trp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_q     (cfg)
  );

  trp_mul #(.B_WIDTH(BW)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go_r),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  // one item in flight: hold off the source until the result is registered
  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // saturating tick count and phase boundaries
  assign tick_inc = (&tick_r) ? tick_r : tick_r + COUNT_WIDTH'(1);
  assign t_e      = EW'(tick_inc);
  assign up_e     = EW'(cfg.up_ticks);
  assign sd_e     = up_e + EW'(cfg.hold_ticks);
  assign total_e  = sd_e + EW'(cfg.down_ticks);
  assign advance  = (in_data.op == OP_TICK) & in_data.sensors_ready
                    & running_r & ~finished_r;

  // operand select for the current multiply step
  always_comb begin
    case (step_r)
      SP_ST:   begin mul_a = PROD_WIDTH'(cfg.rate_step); mul_b = t_r; end
      SP_KT:   begin mul_a = keep_r;                     mul_b = t_r; end
      SP_SU:   begin mul_a = PROD_WIDTH'(cfg.rate_step); mul_b = BW'(cfg.up_ticks); end
      SP_KU:   begin mul_a = keep_r;                     mul_b = BW'(cfg.up_ticks); end
      SP_PT:   begin mul_a = PROD_WIDTH'(cfg.peak_rate); mul_b = tu_r; end
      SP_SD:   begin mul_a = PROD_WIDTH'(cfg.rate_step); mul_b = d_r; end
      SP_KD:   begin mul_a = keep_r;                     mul_b = d_r; end
      default: begin mul_a = '0;                         mul_b = '0; end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    go_nxt        = 1'b0;
    tick_nxt      = tick_r;
    running_nxt   = running_r;
    finished_nxt  = finished_r;
    sp_nxt        = sp_r;
    donef_nxt     = donef_r;
    phase_nxt     = phase_r;
    rate_nxt      = rate_r;
    x_nxt         = x_r;
    keep_nxt      = keep_r;
    t_nxt         = t_r;
    tu_nxt        = tu_r;
    d_nxt         = d_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    // drain the output register
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          sp_nxt    = 1'b0;
          donef_nxt = 1'b0;
          state_nxt = ST_EMIT;
          case (in_data.op)
            OP_START: begin
              tick_nxt    = '0;
              running_nxt = 1'b1;
            end
            OP_STOP: begin
              running_nxt = 1'b0;
            end
            default: begin
              // ticks that do not advance and the unknown op fall through
              if (advance) begin
                tick_nxt = tick_inc;
                if (t_e >= total_e) begin
                  finished_nxt = 1'b1;
                  donef_nxt    = 1'b1;
                end else begin
                  sp_nxt    = 1'b1;
                  t_nxt     = BW'(tick_inc);
                  tu_nxt    = BW'(t_e - up_e);
                  d_nxt     = BW'(t_e - sd_e);
                  go_nxt    = 1'b1;
                  state_nxt = ST_MUL;
                  if (t_e <= up_e) begin
                    phase_nxt = PH_UP;
                    step_nxt  = SP_ST;
                  end else if (t_e <= sd_e) begin
                    phase_nxt = PH_HOLD;
                    step_nxt  = SP_SU;
                    rate_nxt  = cfg.peak_rate;
                  end else begin
                    phase_nxt = PH_DOWN;
                    step_nxt  = SP_SU;
                  end
                end
              end
            end
          endcase
        end
      end

      ST_MUL: begin
        if (mul_done) begin
          case (step_r)
            SP_ST: begin
              keep_nxt = mul_prod;
              rate_nxt = (|mul_prod[PROD_WIDTH-1:RATE_WIDTH]) ? '1
                                                              : mul_prod[RATE_WIDTH-1:0];
              step_nxt = SP_KT;
              go_nxt   = 1'b1;
            end
            SP_KT: begin
              x_nxt     = mul_prod[ACC_WIDTH-1:0];
              state_nxt = ST_EMIT;
            end
            SP_SU: begin
              keep_nxt = mul_prod;
              step_nxt = SP_KU;
              go_nxt   = 1'b1;
            end
            SP_KU: begin
              x_nxt    = mul_prod[ACC_WIDTH-1:0];
              step_nxt = SP_PT;
              go_nxt   = 1'b1;
            end
            SP_PT: begin
              // H + d equals t - U, so one product covers both plateau terms
              x_nxt = x_r + {mul_prod[ACC_WIDTH-2:0], 1'b0};
              if (phase_r == PH_HOLD) begin
                state_nxt = ST_EMIT;
              end else begin
                step_nxt = SP_SD;
                go_nxt   = 1'b1;
              end
            end
            SP_SD: begin
              keep_nxt = mul_prod;
              rate_nxt = (mul_prod >= PROD_WIDTH'(cfg.peak_rate)) ? '0
                         : cfg.peak_rate - mul_prod[RATE_WIDTH-1:0];
              step_nxt = SP_KD;
              go_nxt   = 1'b1;
            end
            SP_KD: begin
              x_nxt     = x_r - mul_prod[ACC_WIDTH-1:0];
              state_nxt = ST_EMIT;
            end
            default: begin
              state_nxt = ST_EMIT;
            end
          endcase
        end
      end

      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt                = 1'b1;
          out_data_nxt.setpoint_valid  = sp_r;
          out_data_nxt.rate_out        = sp_r ? rate_r : '0;
          out_data_nxt.angle_out       = sp_r ? x_r[ACC_WIDTH-1:1] : '0;
          out_data_nxt.phase           = sp_r ? phase_r : PH_STOP;
          out_data_nxt.done_res        = donef_r;
          out_data_nxt.armed           = running_r & ~finished_r;
          state_nxt                    = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= SP_ST;
      go_r        <= 1'b0;
      tick_r      <= '0;
      running_r   <= 1'b0;
      finished_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      go_r        <= go_nxt;
      tick_r      <= tick_nxt;
      running_r   <= running_nxt;
      finished_r  <= finished_nxt;
      out_valid_r <= out_valid_nxt;
    end
    sp_r       <= sp_nxt;
    donef_r    <= donef_nxt;
    phase_r    <= phase_nxt;
    rate_r     <= rate_nxt;
    x_r        <= x_nxt;
    keep_r     <= keep_nxt;
    t_r        <= t_nxt;
    tu_r       <= tu_nxt;
    d_r        <= d_nxt;
    out_data_r <= out_data_nxt;
  end

  // a product only comes back while a tick is being worked
  assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> state_r == ST_MUL)
    else $error("multiplier finished outside the multiply state");

  // completion stays latched until reset
  assert property (@(posedge clk) disable iff (!rst_n)
    finished_r |=> finished_r)
    else $error("completion latch dropped");

  // a setpoint never carries the stopped phase or the done pulse
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.setpoint_valid
      |-> out_data_r.phase != PH_STOP && !out_data_r.done_res)
    else $error("setpoint with stopped phase or done");

  // the done pulse goes with a latched completion and a disarmed unit
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.done_res |-> finished_r && !out_data_r.armed)
    else $error("done pulse without completion latched");

endmodule
